### rtl/core/crm_pkg.sv
package crm_pkg;

  localparam int LIT_W      = 21;
  localparam int PIV_W      = 20;
  localparam int SIZE_W     = 6;
  localparam int RESULT_CAP = 62;

  typedef enum logic [1:0] {
    ST_LIT   = 2'd0,
    ST_TAUT  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_OVF   = 2'd3
  } status_t;

  typedef struct packed {
    logic             kind;
    logic [LIT_W-1:0] literal;
    logic [PIV_W-1:0] pivot_var;
    logic             clause_end;
  } item_t;

  typedef struct packed {
    logic [LIT_W-1:0]  out_literal;
    status_t           status;
    logic [SIZE_W-1:0] resolvent_size;
    logic              last;
  } result_t;

  // merge launch, from the load side to the engine
  typedef struct packed {
    logic              start;
    logic              big_second;
    logic              ovf;
    logic [SIZE_W-1:0] small_n;
    logic [SIZE_W-1:0] big_n;
  } job_t;

endpackage

### rtl/core/crm_stream_if.sv
interface crm_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/crm_store.sv
module crm_store #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 21,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/crm_engine.sv
module crm_engine #(
  parameter int MAX_CLAUSE_LEN = 32,
  parameter int VAR_BITS = 20,
  localparam int AW = $clog2(MAX_CLAUSE_LEN),
  localparam int LW = VAR_BITS + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  crm_pkg::job_t       job,
  input  logic [VAR_BITS-1:0] pivot,
  output logic                idle,
  output logic [AW-1:0]       first_addr,
  output logic [AW-1:0]       second_addr,
  input  logic [LW-1:0]       first_data,
  input  logic [LW-1:0]       second_data,
  crm_stream_if.source        results
);
  import crm_pkg::*;

  localparam int CW = $clog2(MAX_CLAUSE_LEN + 1);
  localparam int NW = SIZE_W + 1;

  typedef enum logic [3:0] {
    IDLE,
    SM_ADDR,
    SM_DATA,
    BG_ADDR,
    BG_DATA,
    BC_ADDR,
    BC_DATA,
    SIZE_CALC,
    EM_ADDR,
    EM_DATA,
    EM_OUT,
    FIN_OUT
  } state_t;

  state_t                state;
  logic                  big_second;
  logic                  ovf;
  logic                  flag;
  logic                  emit_big;
  logic [CW-1:0]         ns;
  logic [CW-1:0]         nb;
  logic [CW-1:0]         i;
  logic [CW-1:0]         j;
  logic [CW-1:0]         kept;
  logic [CW-1:0]         bkept;
  logic [MAX_CLAUSE_LEN-1:0] keep;
  logic [LW-1:0]         s_lit;
  logic [SIZE_W-1:0]     e;
  logic [SIZE_W-1:0]     sent;
  logic [VAR_BITS-1:0]   piv;

  logic [AW-1:0]         small_addr;
  logic [AW-1:0]         big_addr;
  logic [LW-1:0]         small_data;
  logic [LW-1:0]         big_data;
  logic [LW-1:0]         cur;
  logic [VAR_BITS-1:0]   cmp_ref;
  logic                  var_eq;
  logic [NW-1:0]         n_sum;
  logic [NW-1:0]         lim;
  logic                  flag_now;
  logic [SIZE_W-1:0]     e_now;

  assign small_addr  = i[AW-1:0];
  assign big_addr    = j[AW-1:0];
  assign first_addr  = big_second ? small_addr : big_addr;
  assign second_addr = big_second ? big_addr : small_addr;
  assign small_data  = big_second ? first_data : second_data;
  assign big_data    = big_second ? second_data : first_data;
  assign idle        = (state == IDLE);

  // shared variable comparator
  always_comb begin
    if (state == SM_DATA || (state == EM_DATA && !emit_big)) begin
      cur = small_data;
    end else begin
      cur = big_data;
    end
    if (state == BG_DATA) begin
      cmp_ref = s_lit[LW-1:1];
    end else begin
      cmp_ref = piv;
    end
    var_eq = (cur[LW-1:1] == cmp_ref);
  end

  always_comb begin
    n_sum    = NW'(kept) + NW'(bkept);
    flag_now = ovf || (n_sum > NW'(RESULT_CAP));
    lim      = flag_now ? NW'(RESULT_CAP - 1) : NW'(RESULT_CAP);
    e_now    = (n_sum < lim) ? SIZE_W'(n_sum) : SIZE_W'(lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      results.valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (job.start) begin
            big_second <= job.big_second;
            ovf        <= job.ovf;
            ns         <= CW'(job.small_n);
            nb         <= CW'(job.big_n);
            piv        <= pivot;
            i          <= '0;
            j          <= '0;
            kept       <= '0;
            bkept      <= '0;
            state      <= SM_ADDR;
          end
        end
        SM_ADDR: begin
          if (i == ns) begin
            j     <= '0;
            state <= BC_ADDR;
          end else begin
            state <= SM_DATA;
          end
        end
        SM_DATA: begin
          if (var_eq) begin
            keep[i[AW-1:0]] <= 1'b0;
            i               <= i + CW'(1);
            state           <= SM_ADDR;
          end else begin
            s_lit <= cur;
            j     <= '0;
            state <= BG_ADDR;
          end
        end
        BG_ADDR: begin
          if (j == nb) begin
            keep[i[AW-1:0]] <= 1'b1;
            kept            <= kept + CW'(1);
            i               <= i + CW'(1);
            state           <= SM_ADDR;
          end else begin
            state <= BG_DATA;
          end
        end
        BG_DATA: begin
          if (var_eq) begin
            if (cur[0] != s_lit[0]) begin
              results.valid                  <= 1'b1;
              results.payload.out_literal    <= '0;
              results.payload.status         <= ST_TAUT;
              results.payload.resolvent_size <= '0;
              results.payload.last           <= 1'b1;
              state                          <= FIN_OUT;
            end else begin
              keep[i[AW-1:0]] <= 1'b0;
              i               <= i + CW'(1);
              state           <= SM_ADDR;
            end
          end else begin
            j     <= j + CW'(1);
            state <= BG_ADDR;
          end
        end
        BC_ADDR: begin
          if (j == nb) begin
            state <= SIZE_CALC;
          end else begin
            state <= BC_DATA;
          end
        end
        BC_DATA: begin
          if (!var_eq) begin
            bkept <= bkept + CW'(1);
          end
          j     <= j + CW'(1);
          state <= BC_ADDR;
        end
        SIZE_CALC: begin
          flag     <= flag_now;
          e        <= e_now;
          sent     <= '0;
          i        <= '0;
          j        <= '0;
          emit_big <= 1'b0;
          state    <= EM_ADDR;
        end
        EM_ADDR: begin
          if (sent == e) begin
            if (flag) begin
              results.valid                  <= 1'b1;
              results.payload.out_literal    <= '0;
              results.payload.status         <= ST_OVF;
              results.payload.resolvent_size <= e;
              results.payload.last           <= 1'b1;
              state                          <= FIN_OUT;
            end else if (e == '0) begin
              results.valid                  <= 1'b1;
              results.payload.out_literal    <= '0;
              results.payload.status         <= ST_EMPTY;
              results.payload.resolvent_size <= '0;
              results.payload.last           <= 1'b1;
              state                          <= FIN_OUT;
            end else begin
              state <= IDLE;
            end
          end else if (!emit_big) begin
            if (i == ns) begin
              emit_big <= 1'b1;
            end else if (!keep[i[AW-1:0]]) begin
              i <= i + CW'(1);
            end else begin
              state <= EM_DATA;
            end
          end else begin
            state <= EM_DATA;
          end
        end
        EM_DATA: begin
          if (emit_big && var_eq) begin
            j     <= j + CW'(1);
            state <= EM_ADDR;
          end else begin
            results.valid                  <= 1'b1;
            results.payload.out_literal    <= LIT_W'(cur);
            results.payload.status         <= ST_LIT;
            results.payload.resolvent_size <= e;
            results.payload.last           <= !flag && ((sent + SIZE_W'(1)) == e);
            sent                           <= sent + SIZE_W'(1);
            if (emit_big) begin
              j <= j + CW'(1);
            end else begin
              i <= i + CW'(1);
            end
            state <= EM_OUT;
          end
        end
        EM_OUT: begin
          if (results.ready) begin
            results.valid <= 1'b0;
            state         <= results.payload.last ? IDLE : EM_ADDR;
          end
        end
        FIN_OUT: begin
          if (results.ready) begin
            results.valid <= 1'b0;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/clause_resolvent_merge.sv
// Channel   Dir  Payload    Notes
// items     in   item_t     one literal per request, kind picks the clause
// results   out  result_t   resolvent literals and/or a status, last marks the end
//
// Load: one literal per cycle while idle. A second-clause literal with clause_end starts the merge.
// Merge: each smaller-clause literal is looked up in the larger clause, then the
// larger-clause entries other than the pivot are counted, then results are emitted;
// one shared variable comparator and one read port per clause store serve all steps.
// items.ready is low for the whole merge; a stalled result holds the engine.
// Synchronous reset clears counts, pivot, overflow and the sequencer.
module clause_resolvent_merge #(
  parameter int MAX_CLAUSE_LEN = 32,
  parameter int VAR_BITS = 20
) (
  input logic          clk,
  input logic          rst,
  crm_stream_if.sink   items,
  crm_stream_if.source results
);
  import crm_pkg::*;

  localparam int AW = $clog2(MAX_CLAUSE_LEN);
  localparam int CW = $clog2(MAX_CLAUSE_LEN + 1);
  localparam int LW = VAR_BITS + 1;

  logic [CW-1:0]       first_count;
  logic [CW-1:0]       second_count;
  logic [CW-1:0]       first_next;
  logic [CW-1:0]       second_next;
  logic [VAR_BITS-1:0] pivot_reg;
  logic                overflow_flag;

  logic                take;
  logic                first_full;
  logic                second_full;
  logic                first_we;
  logic                second_we;
  logic                drop;
  logic [LW-1:0]       lit_in;
  job_t                job;
  logic                idle;
  logic [AW-1:0]       first_addr;
  logic [AW-1:0]       second_addr;
  logic [LW-1:0]       first_data;
  logic [LW-1:0]       second_data;

  assign items.ready = idle;
  assign take        = items.valid && idle;
  assign lit_in      = LW'(items.payload.literal);
  assign first_full  = (first_count == CW'(MAX_CLAUSE_LEN));
  assign second_full = (second_count == CW'(MAX_CLAUSE_LEN));
  assign first_we    = take && !items.payload.kind && !first_full;
  assign second_we   = take && items.payload.kind && !second_full;
  assign drop        = take && (items.payload.kind ? second_full : first_full);
  assign first_next  = first_count + CW'(first_we);
  assign second_next = second_count + CW'(second_we);

  always_comb begin
    job.start      = take && items.payload.kind && items.payload.clause_end;
    job.big_second = (first_next < second_next);
    job.ovf        = overflow_flag || drop;
    if (job.big_second) begin
      job.small_n = SIZE_W'(first_next);
      job.big_n   = SIZE_W'(second_next);
    end else begin
      job.small_n = SIZE_W'(second_next);
      job.big_n   = SIZE_W'(first_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_count   <= '0;
      second_count  <= '0;
      pivot_reg     <= '0;
      overflow_flag <= 1'b0;
    end else if (job.start) begin
      first_count   <= '0;
      second_count  <= '0;
      overflow_flag <= 1'b0;
    end else if (take) begin
      if (!items.payload.kind && first_count == '0) begin
        pivot_reg <= VAR_BITS'(items.payload.pivot_var);
      end
      first_count  <= first_next;
      second_count <= second_next;
      if (drop) begin
        overflow_flag <= 1'b1;
      end
    end
  end

  crm_store #(
    .DEPTH(MAX_CLAUSE_LEN),
    .WIDTH(LW)
  ) u_first_store (
    .clk  (clk),
    .we   (first_we),
    .waddr(first_count[AW-1:0]),
    .wdata(lit_in),
    .raddr(first_addr),
    .rdata(first_data)
  );

  crm_store #(
    .DEPTH(MAX_CLAUSE_LEN),
    .WIDTH(LW)
  ) u_second_store (
    .clk  (clk),
    .we   (second_we),
    .waddr(second_count[AW-1:0]),
    .wdata(lit_in),
    .raddr(second_addr),
    .rdata(second_data)
  );

  crm_engine #(
    .MAX_CLAUSE_LEN(MAX_CLAUSE_LEN),
    .VAR_BITS(VAR_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .job        (job),
    .pivot      (pivot_reg),
    .idle       (idle),
    .first_addr (first_addr),
    .second_addr(second_addr),
    .first_data (first_data),
    .second_data(second_data),
    .results    (results)
  );

endmodule

### rtl/core/crm_checker.sv
module crm_checker (
  input logic             clk,
  input logic             rst,
  input logic             items_ready,
  input logic             results_valid,
  input logic             results_ready,
  input crm_pkg::result_t results_payload
);
  import crm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    results_valid && !results_ready |=> results_valid && $stable(results_payload))
    else $error("result changed while stalled");

  a_busy_excl: assert property (@(posedge clk) disable iff (rst)
    items_ready |-> !results_valid)
    else $error("request taken while a result is pending");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    results_valid && results_payload.status != ST_LIT |-> results_payload.last)
    else $error("status result without last");

  a_taut_size: assert property (@(posedge clk) disable iff (rst)
    results_valid && results_payload.status == ST_TAUT |->
      results_payload.resolvent_size == '0)
    else $error("tautology with nonzero size");

  a_ready_after: assert property (@(posedge clk) disable iff (rst)
    results_valid && results_ready && results_payload.last |=> items_ready)
    else $error("not ready after merge completed");

endmodule

bind clause_resolvent_merge crm_checker u_crm_checker (
  .clk            (clk),
  .rst            (rst),
  .items_ready    (items.ready),
  .results_valid  (results.valid),
  .results_ready  (results.ready),
  .results_payload(results.payload)
);
